[design/slt_pkg.sv]
// Shared types and codes of the shell line tokenizer.
package slt_pkg;

    // Result kinds
    localparam logic [2:0] KIND_BYTE  = 3'd0;
    localparam logic [2:0] KIND_EOT   = 3'd1;
    localparam logic [2:0] KIND_OP    = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // Operator codes
    localparam logic [2:0] OP_PIPE     = 3'd0;
    localparam logic [2:0] OP_LESS     = 3'd1;
    localparam logic [2:0] OP_GREATER  = 3'd2;
    localparam logic [2:0] OP_AMP      = 3'd3;
    localparam logic [2:0] OP_SEMI     = 3'd4;
    localparam logic [2:0] OP_DGREATER = 3'd5;

    // Lexer modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SQUOTE = 3'd1;
    localparam logic [2:0] MODE_DQUOTE = 3'd2;
    localparam logic [2:0] MODE_ESC    = 3'd3;
    localparam logic [2:0] MODE_DQ_ESC = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // Most results one byte can cause
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] token_byte;
        logic [2:0] operator_code;
    } result_t;

    // All results of one input byte, queued as one entry
    typedef struct packed {
        logic [1:0]                  count;
        result_t [MAX_RES-1:0]       res;
    } bundle_t;

endpackage

[design/slt_if.sv]
// Stream interfaces for line bytes in and token results out.
interface slt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_line;

    modport source (output valid, output char_byte, output end_of_line, input ready);
    modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

interface slt_tok_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] token_byte;
    logic [2:0] operator_code;
    logic       last_of_run;

    modport source (output valid, output kind, output token_byte, output operator_code,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input token_byte, input operator_code,
                    input last_of_run, output ready);
endinterface

[design/shell_line_tokenizer.sv]
// Top level of the shell line tokenizer: front end, bundle queue, back end.
//
//   channel  dir  payload                                        role
//   chars    in   char_byte[8], end_of_line                      one line byte per request
//   tokens   out  kind[3], token_byte[8], operator_code[3], last result stream
//
// A byte is taken every cycle while the queue has room; its results (zero to
// three) are queued as one bundle, unless there are none, and leave one per
// cycle while the output is ready, so the output side sets the sustained rate.
// Reset clears lexer state, queue pointers and the result index.
// A stalled output fills the QUEUE_DEPTH-entry queue, then input ready drops.
module shell_line_tokenizer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    slt_char_if.sink   chars,
    slt_tok_if.source  tokens
);

    logic             push, pop, full, empty;
    slt_pkg::bundle_t push_data, head;

    slt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .q_full    (full),
        .push      (push),
        .push_data (push_data)
    );

    slt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    slt_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

[design/slt_front.sv]
// Front end: accepts line bytes, tracks lexer state, builds result bundles.
module slt_front
(
    input  logic             clk,
    input  logic             rst_n,
    slt_char_if.sink         chars,
    input  logic             q_full,
    output logic             push,
    output slt_pkg::bundle_t push_data
);

    logic [2:0] mode_reg, mode_next;
    logic       word_open_reg, word_open_next;
    logic       held_reg, held_next;

    logic       accept;
    logic [7:0] c;
    logic       blank;
    logic       is_op;
    logic [2:0] op;
    logic [1:0] n;
    slt_pkg::result_t [slt_pkg::MAX_RES-1:0] res;

    assign chars.ready = !q_full;
    assign accept      = chars.valid && chars.ready;
    assign c           = chars.char_byte;
    assign blank       = (c == slt_pkg::CH_SPACE) ||
                         ((c >= slt_pkg::CH_TAB) && (c <= slt_pkg::CH_CR));

    // Decode operator characters
    always_comb
    begin
        is_op = 1'b1;
        op    = slt_pkg::OP_PIPE;
        unique case (c)
            slt_pkg::CH_PIPE:    op = slt_pkg::OP_PIPE;
            slt_pkg::CH_LESS:    op = slt_pkg::OP_LESS;
            slt_pkg::CH_GREATER: op = slt_pkg::OP_GREATER;
            slt_pkg::CH_AMP:     op = slt_pkg::OP_AMP;
            slt_pkg::CH_SEMI:    op = slt_pkg::OP_SEMI;
            default:             is_op = 1'b0;
        endcase
    end

    // Build the results of this byte and the next lexer state
    always_comb
    begin
        mode_next      = mode_reg;
        word_open_next = word_open_reg;
        held_next      = held_reg;
        n              = 2'd0;
        res            = '0;

        if (chars.end_of_line)
        begin
            if (held_reg)
            begin
                res[n].kind          = slt_pkg::KIND_OP;
                res[n].operator_code = slt_pkg::OP_GREATER;
                n = n + 2'd1;
            end
            if (mode_reg != slt_pkg::MODE_NORMAL)
            begin
                res[n].kind = slt_pkg::KIND_ERR;
                n = n + 2'd1;
            end
            else
            begin
                if (word_open_reg)
                begin
                    res[n].kind = slt_pkg::KIND_EOT;
                    n = n + 2'd1;
                end
                res[n].kind = slt_pkg::KIND_DONE;
                n = n + 2'd1;
            end
            mode_next      = slt_pkg::MODE_NORMAL;
            word_open_next = 1'b0;
            held_next      = 1'b0;
        end
        else if (held_reg && (c == slt_pkg::CH_GREATER))
        begin
            // Pair the held greater into a double greater
            res[n].kind          = slt_pkg::KIND_OP;
            res[n].operator_code = slt_pkg::OP_DGREATER;
            n = n + 2'd1;
            held_next = 1'b0;
        end
        else
        begin
            if (held_reg)
            begin
                res[n].kind          = slt_pkg::KIND_OP;
                res[n].operator_code = slt_pkg::OP_GREATER;
                n = n + 2'd1;
                held_next = 1'b0;
            end

            unique case (mode_reg)
                slt_pkg::MODE_ESC:
                begin
                    res[n].token_byte = c;
                    n = n + 2'd1;
                    word_open_next = 1'b1;
                    mode_next      = slt_pkg::MODE_NORMAL;
                end
                slt_pkg::MODE_DQ_ESC:
                begin
                    res[n].token_byte = c;
                    n = n + 2'd1;
                    word_open_next = 1'b1;
                    mode_next      = slt_pkg::MODE_DQUOTE;
                end
                slt_pkg::MODE_SQUOTE:
                begin
                    if (c == slt_pkg::CH_SQUOTE)
                        mode_next = slt_pkg::MODE_NORMAL;
                    else
                    begin
                        res[n].token_byte = c;
                        n = n + 2'd1;
                        word_open_next = 1'b1;
                    end
                end
                slt_pkg::MODE_DQUOTE:
                begin
                    if (c == slt_pkg::CH_DQUOTE)
                        mode_next = slt_pkg::MODE_NORMAL;
                    else if (c == slt_pkg::CH_BSLASH)
                        mode_next = slt_pkg::MODE_DQ_ESC;
                    else
                    begin
                        res[n].token_byte = c;
                        n = n + 2'd1;
                        word_open_next = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = slt_pkg::MODE_NORMAL;
                    if (blank)
                    begin
                        if (word_open_reg)
                        begin
                            res[n].kind = slt_pkg::KIND_EOT;
                            n = n + 2'd1;
                        end
                        word_open_next = 1'b0;
                    end
                    else if (c == slt_pkg::CH_BSLASH)
                        mode_next = slt_pkg::MODE_ESC;
                    else if (c == slt_pkg::CH_SQUOTE)
                        mode_next = slt_pkg::MODE_SQUOTE;
                    else if (c == slt_pkg::CH_DQUOTE)
                        mode_next = slt_pkg::MODE_DQUOTE;
                    else if (is_op)
                    begin
                        if (word_open_reg)
                        begin
                            res[n].kind = slt_pkg::KIND_EOT;
                            n = n + 2'd1;
                        end
                        word_open_next = 1'b0;
                        if (c == slt_pkg::CH_GREATER)
                            held_next = 1'b1;
                        else
                        begin
                            res[n].kind          = slt_pkg::KIND_OP;
                            res[n].operator_code = op;
                            n = n + 2'd1;
                        end
                    end
                    else
                    begin
                        res[n].token_byte = c;
                        n = n + 2'd1;
                        word_open_next = 1'b1;
                    end
                end
            endcase
        end
    end

    // Queue only bytes that cause results
    assign push            = accept && (n != 2'd0);
    assign push_data.count = n;
    assign push_data.res   = res;

    // Advance lexer state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= slt_pkg::MODE_NORMAL;
            word_open_reg <= 1'b0;
            held_reg      <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            word_open_reg <= word_open_next;
            held_reg      <= held_next;
        end
    end

endmodule

[design/slt_queue.sv]
// Short register queue of result bundles between front and back.
module slt_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  slt_pkg::bundle_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output slt_pkg::bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slt_pkg::bundle_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Store incoming bundles
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[design/slt_back.sv]
// Back end: plays out the results of each queued bundle one per cycle while the token side is ready.
module slt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  slt_pkg::bundle_t head,
    output logic             pop,
    slt_tok_if.source        tokens
);

    logic [1:0] sub_reg, sub_next;
    logic       last;
    logic       take;

    assign last  = (sub_reg == (head.count - 2'd1));
    assign take  = tokens.valid && tokens.ready;
    assign pop   = take && last;

    assign tokens.valid         = !empty;
    assign tokens.kind          = head.res[sub_reg].kind;
    assign tokens.token_byte    = head.res[sub_reg].token_byte;
    assign tokens.operator_code = head.res[sub_reg].operator_code;
    assign tokens.last_of_run   = last;

    // Step through the bundle, restart on the next one
    always_comb
    begin
        sub_next = sub_reg;
        if (pop)
            sub_next = 2'd0;
        else if (take)
            sub_next = sub_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= 2'd0;
        else
            sub_reg <= sub_next;
    end

endmodule

[tb/shell_line_tokenizer_tb.sv]
// Testbench for shell_line_tokenizer: directed table, random command lines, scoreboard.
module shell_line_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected or observed token-side request
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] token_byte;
        logic [2:0] operator_code;
        logic       last_of_run;
    } token_rec_t;

    // One row of the directed table; pinned rows carry at most one result
    typedef struct packed {
        logic [7:0]       ch;
        logic             eol;
        logic             pinned;
        logic             has_res;
        slt_pkg::result_t res;
    } line_row_t;

    localparam int DIRECTED_ROWS = 28;
    localparam int RANDOM_ITEMS  = 172;
    localparam int QUIET_FROM    = 140;
    localparam int DRAIN_CYCLES  = 20;

    logic clk;
    logic rst_n;

    slt_char_if chars_bus ();
    slt_tok_if  tokens_bus ();

    shell_line_tokenizer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_bus.sink),
        .tokens (tokens_bus.source)
    );

    // Lexer state mirrored from the block
    logic [2:0] lex_mode;
    logic       word_open;
    logic       held_greater;

    token_rec_t lex_run[$];
    token_rec_t pending_tokens[$];
    line_row_t  line_table[DIRECTED_ROWS];

    int  mismatches;
    int  random_items;
    int  stall_left;
    bit  quiet;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Print one mismatch line and count it
    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic line_row_t free_row(input logic [7:0] ch, input logic eol);
        line_row_t r;
        r = '0;
        r.ch  = ch;
        r.eol = eol;
        return r;
    endfunction

    function automatic line_row_t silent_row(input logic [7:0] ch);
        line_row_t r;
        r = free_row(ch, 1'b0);
        r.pinned = 1'b1;
        return r;
    endfunction

    function automatic line_row_t pinned_row(input logic [7:0] ch, input logic eol,
                                             input logic [2:0] kind, input logic [7:0] tb,
                                             input logic [2:0] op);
        line_row_t r;
        r = free_row(ch, eol);
        r.pinned  = 1'b1;
        r.has_res = 1'b1;
        r.res.kind          = kind;
        r.res.token_byte    = tb;
        r.res.operator_code = op;
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == slt_pkg::CH_SPACE) || (ch >= slt_pkg::CH_TAB && ch <= slt_pkg::CH_CR);
    endfunction

    function automatic logic operator_of(input logic [7:0] ch, output logic [2:0] code);
        code = slt_pkg::OP_PIPE;
        case (ch)
            slt_pkg::CH_PIPE:    code = slt_pkg::OP_PIPE;
            slt_pkg::CH_LESS:    code = slt_pkg::OP_LESS;
            slt_pkg::CH_GREATER: code = slt_pkg::OP_GREATER;
            slt_pkg::CH_AMP:     code = slt_pkg::OP_AMP;
            slt_pkg::CH_SEMI:    code = slt_pkg::OP_SEMI;
            default:             return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void put_token(input logic [2:0] kind, input logic [7:0] tb,
                                      input logic [2:0] op);
        token_rec_t r;
        r.kind          = kind;
        r.token_byte    = tb;
        r.operator_code = op;
        r.last_of_run   = 1'b0;
        lex_run.push_back(r);
    endfunction

    function automatic void add_word_byte(input logic [7:0] ch);
        word_open = 1'b1;
        put_token(slt_pkg::KIND_BYTE, ch, '0);
    endfunction

    function automatic void close_word();
        if (word_open)
            put_token(slt_pkg::KIND_EOT, '0, '0);
        word_open = 1'b0;
    endfunction

    // Advance the lexer by one request and collect its tokens in lex_run
    function automatic void tokenize_byte(input logic [7:0] ch, input logic eol);
        logic [2:0] op;
        logic       dgreater;
        lex_run.delete();
        dgreater = 1'b0;
        if (eol)
        begin
            if (held_greater)
                put_token(slt_pkg::KIND_OP, '0, slt_pkg::OP_GREATER);
            if (lex_mode != slt_pkg::MODE_NORMAL)
                put_token(slt_pkg::KIND_ERR, '0, '0);
            else
            begin
                if (word_open)
                    put_token(slt_pkg::KIND_EOT, '0, '0);
                put_token(slt_pkg::KIND_DONE, '0, '0);
            end
            lex_mode     = slt_pkg::MODE_NORMAL;
            word_open    = 1'b0;
            held_greater = 1'b0;
        end
        else
        begin
            // Release a held greater, or fuse it with this one
            if (held_greater)
            begin
                held_greater = 1'b0;
                if (ch == slt_pkg::CH_GREATER)
                begin
                    put_token(slt_pkg::KIND_OP, '0, slt_pkg::OP_DGREATER);
                    dgreater = 1'b1;
                end
                else
                    put_token(slt_pkg::KIND_OP, '0, slt_pkg::OP_GREATER);
            end
            if (!dgreater)
            begin
                case (lex_mode)
                    slt_pkg::MODE_ESC:
                    begin
                        add_word_byte(ch);
                        lex_mode = slt_pkg::MODE_NORMAL;
                    end
                    slt_pkg::MODE_DQ_ESC:
                    begin
                        add_word_byte(ch);
                        lex_mode = slt_pkg::MODE_DQUOTE;
                    end
                    slt_pkg::MODE_SQUOTE:
                    begin
                        if (ch == slt_pkg::CH_SQUOTE)
                            lex_mode = slt_pkg::MODE_NORMAL;
                        else
                            add_word_byte(ch);
                    end
                    slt_pkg::MODE_DQUOTE:
                    begin
                        if (ch == slt_pkg::CH_DQUOTE)
                            lex_mode = slt_pkg::MODE_NORMAL;
                        else if (ch == slt_pkg::CH_BSLASH)
                            lex_mode = slt_pkg::MODE_DQ_ESC;
                        else
                            add_word_byte(ch);
                    end
                    default:
                    begin
                        lex_mode = slt_pkg::MODE_NORMAL;
                        if (is_blank(ch))
                            close_word();
                        else if (ch == slt_pkg::CH_BSLASH)
                            lex_mode = slt_pkg::MODE_ESC;
                        else if (ch == slt_pkg::CH_SQUOTE)
                            lex_mode = slt_pkg::MODE_SQUOTE;
                        else if (ch == slt_pkg::CH_DQUOTE)
                            lex_mode = slt_pkg::MODE_DQUOTE;
                        else if (operator_of(ch, op))
                        begin
                            close_word();
                            if (ch == slt_pkg::CH_GREATER)
                                held_greater = 1'b1;
                            else
                                put_token(slt_pkg::KIND_OP, '0, op);
                        end
                        else
                            add_word_byte(ch);
                    end
                endcase
            end
        end
    endfunction

    // Mark the final token of the run and queue the run for checking
    function automatic void queue_run();
        if (lex_run.size() > 0)
            lex_run[lex_run.size()-1].last_of_run = 1'b1;
        foreach (lex_run[i])
            pending_tokens.push_back(lex_run[i]);
    endfunction

    task automatic drive_request(input logic [7:0] ch, input logic eol);
        @(negedge clk);
        chars_bus.valid       <= 1'b1;
        chars_bus.char_byte   <= ch;
        chars_bus.end_of_line <= eol;
        do
            @(posedge clk);
        while (!chars_bus.ready);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        chars_bus.valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 5) == 0)
            hold_off($urandom_range(1, 15));
    endtask

    task automatic wait_drained();
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // Send one predicted request
    task automatic send_byte(input logic [7:0] ch, input logic eol);
        maybe_idle();
        drive_request(ch, eol);
        tokenize_byte(ch, eol);
        queue_run();
        random_items++;
        if (random_items >= QUIET_FROM)
            quiet = 1'b1;
    endtask

    // Pick a line byte, weighted toward letters, blanks and lexer specials
    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (sel < 52)
        begin
            case ($urandom_range(0, 5))
                0:       return slt_pkg::CH_SPACE;
                1:       return slt_pkg::CH_TAB;
                2:       return slt_pkg::CH_CR;
                default: return 8'($urandom_range(slt_pkg::CH_TAB, slt_pkg::CH_CR));
            endcase
        end
        else if (sel < 70)
        begin
            case ($urandom_range(0, 5))
                0:       return slt_pkg::CH_PIPE;
                1:       return slt_pkg::CH_LESS;
                2:       return slt_pkg::CH_AMP;
                3:       return slt_pkg::CH_SEMI;
                default: return slt_pkg::CH_GREATER;
            endcase
        end
        else if (sel < 77)
            return slt_pkg::CH_BSLASH;
        else if (sel < 84)
            return slt_pkg::CH_SQUOTE;
        else if (sel < 91)
            return slt_pkg::CH_DQUOTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Token side: stall in random bursts, none once the run goes quiet
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            tokens_bus.ready <= 1'b0;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            tokens_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 14);
        end
        else
            tokens_bus.ready <= 1'b1;
    end

    // Check each token against the oldest expectation
    always @(posedge clk)
    begin
        token_rec_t want;
        if (rst_n && tokens_bus.valid && tokens_bus.ready)
        begin
            if (pending_tokens.size() == 0)
                flag_mismatch($sformatf("unexpected token kind=%0d byte=%02h op=%0d",
                                        tokens_bus.kind, tokens_bus.token_byte,
                                        tokens_bus.operator_code));
            else
            begin
                want = pending_tokens.pop_front();
                if (tokens_bus.kind !== want.kind)
                    flag_mismatch($sformatf("kind got %0d want %0d",
                                            tokens_bus.kind, want.kind));
                if (tokens_bus.token_byte !== want.token_byte)
                    flag_mismatch($sformatf("token_byte got %02h want %02h",
                                            tokens_bus.token_byte, want.token_byte));
                if (tokens_bus.operator_code !== want.operator_code)
                    flag_mismatch($sformatf("operator_code got %0d want %0d",
                                            tokens_bus.operator_code, want.operator_code));
                if (tokens_bus.last_of_run !== want.last_of_run)
                    flag_mismatch($sformatf("last_of_run got %0b want %0b",
                                            tokens_bus.last_of_run, want.last_of_run));
            end
        end
    end

    // Abort a hung run
    initial
    begin
        #3_000_000;
        $display("shell_line_tokenizer verification failed");
        $finish;
    end

    initial
    begin
        int len;
        rst_n                 = 1'b0;
        chars_bus.valid       = 1'b0;
        chars_bus.char_byte   = '0;
        chars_bus.end_of_line = 1'b0;
        tokens_bus.ready      = 1'b0;
        mismatches            = 0;
        random_items          = 0;
        stall_left            = 0;
        quiet                 = 1'b0;
        lex_mode              = slt_pkg::MODE_NORMAL;
        word_open             = 1'b0;
        held_greater          = 1'b0;

        line_table = '{
            pinned_row(8'h00, 1'b1, slt_pkg::KIND_DONE, '0, '0),      // empty line
            pinned_row(8'h00, 1'b0, slt_pkg::KIND_BYTE, 8'h00, '0),   // zero byte is a word byte
            pinned_row(8'hFF, 1'b0, slt_pkg::KIND_BYTE, 8'hFF, '0),
            pinned_row(slt_pkg::CH_SPACE, 1'b0, slt_pkg::KIND_EOT, '0, '0),
            pinned_row(slt_pkg::CH_PIPE, 1'b0, slt_pkg::KIND_OP, '0, slt_pkg::OP_PIPE),
            pinned_row(slt_pkg::CH_LESS, 1'b0, slt_pkg::KIND_OP, '0, slt_pkg::OP_LESS),
            pinned_row(slt_pkg::CH_AMP, 1'b0, slt_pkg::KIND_OP, '0, slt_pkg::OP_AMP),
            pinned_row(slt_pkg::CH_SEMI, 1'b0, slt_pkg::KIND_OP, '0, slt_pkg::OP_SEMI),
            silent_row(slt_pkg::CH_GREATER),                           // hold greater
            pinned_row(slt_pkg::CH_GREATER, 1'b0, slt_pkg::KIND_OP, '0,
                       slt_pkg::OP_DGREATER),
            silent_row(slt_pkg::CH_GREATER),
            free_row(8'h61, 1'b0),                             // held greater then a letter
            free_row(slt_pkg::CH_GREATER, 1'b0),               // word closes before operator
            free_row(8'hFF, 1'b1),                             // held greater at end of line
            silent_row(slt_pkg::CH_BSLASH),
            pinned_row(8'h00, 1'b1, slt_pkg::KIND_ERR, '0, '0),       // open escape at end
            silent_row(slt_pkg::CH_SQUOTE),
            pinned_row(slt_pkg::CH_DQUOTE, 1'b0, slt_pkg::KIND_BYTE, slt_pkg::CH_DQUOTE, '0),
            pinned_row(8'h00, 1'b1, slt_pkg::KIND_ERR, '0, '0),       // open single quote at end
            free_row(slt_pkg::CH_DQUOTE, 1'b0),
            free_row(slt_pkg::CH_BSLASH, 1'b0),
            free_row(slt_pkg::CH_DQUOTE, 1'b0),                // escaped quote inside quotes
            free_row(slt_pkg::CH_DQUOTE, 1'b0),
            free_row(slt_pkg::CH_TAB, 1'b0),
            free_row(slt_pkg::CH_DQUOTE, 1'b0),                // empty quoted word
            free_row(slt_pkg::CH_DQUOTE, 1'b0),
            free_row(slt_pkg::CH_CR, 1'b0),
            pinned_row(8'h00, 1'b1, slt_pkg::KIND_DONE, '0, '0)
        };

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (line_table[i])
        begin
            maybe_idle();
            drive_request(line_table[i].ch, line_table[i].eol);
            tokenize_byte(line_table[i].ch, line_table[i].eol);
            if (line_table[i].pinned)
            begin
                lex_run.delete();
                if (line_table[i].has_res)
                    put_token(line_table[i].res.kind, line_table[i].res.token_byte,
                              line_table[i].res.operator_code);
            end
            queue_run();
        end

        // Let the token side empty out before random lines
        hold_off(1);
        wait_drained();

        // Random lines, with some noise and a drain in the middle
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= RANDOM_ITEMS / 2 && random_items < RANDOM_ITEMS / 2 + 8)
            begin
                hold_off(1);
                wait_drained();
            end
            if ($urandom_range(0, 9) != 0)
            begin
                len = $urandom_range(0, 12);
                repeat (len)
                    send_byte(pick_char(), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end

        @(negedge clk);
        chars_bus.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_tokens.size() != 0)
            flag_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));

        if (mismatches == 0)
            $display("shell_line_tokenizer verification clean");
        else
            $display("shell_line_tokenizer verification failed");
        $finish;
    end

endmodule

[sim.f]
design/slt_pkg.sv
design/slt_if.sv
design/slt_front.sv
design/slt_queue.sv
design/slt_back.sv
design/shell_line_tokenizer.sv
tb/shell_line_tokenizer_tb.sv
